FILE: src/bdd_pkg.sv
// Shared types and constants for the bounded deque with delete.
package bdd_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int DATA_BITS_DEF = 32;
	localparam int OPCODE_W      = 3;
	localparam int VALUE_W       = 32;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 5;
	localparam int WIDE_W        = 64;
	localparam int S_TDATA_W     = 40;
	localparam int M_TDATA_W     = 40;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DELETE     = 3'd4,
		OP_DUMP_FWD   = 3'd5,
		OP_DUMP_BACK  = 3'd6
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_PUSH,
		S_POP,
		S_DEL,
		S_DUMP,
		S_EMIT
	} state_t;

endpackage

FILE: src/bounded_deque_with_delete_top.sv
// Top level of the bounded doubly linked deque with delete by value.
//
// The list lives in memories for the entry values and for the next and previous
// links, each with one write port and one registered read port, so the block walks
// the list one entry per cycle while the output side does not stall, and takes one
// transaction at a time. A push passes through S_PUSH, after S_ALLOC when it reuses
// a freed slot; a pop passes through S_POP; a delete stays in S_DEL for each entry
// compared, the match included; a dump gives one result per cycle unless the output
// stalls. Failed operations on an empty or full list go straight to S_EMIT.
module bounded_deque_with_delete_top
	import bdd_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// opcode [2:0], value [34:3], zero fill above
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// value_out [31:0], status [33:32], entry_count [38:34], zero fill above
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	logic [CW-1:0]        count_q, fresh_q, free_top_q, idx_q;
	logic [IW-1:0]        head_q, tail_q, cur_q;
	opcode_t              op_q;
	logic [DATA_BITS-1:0] val_q;
	status_t              st_q;

	logic                 m_tvalid_q;
	logic [VALUE_W-1:0]   out_value_q;
	status_t              out_status_q;
	logic                 out_last_q;
	logic [COUNT_W-1:0]   out_count_q;

	opcode_t              in_op;
	logic [VALUE_W-1:0]   in_value;
	logic [WIDE_W-1:0]    in_ext;
	logic                 s_fire, out_free, out_load, hit, at_last, dump_back;

	logic [IW-1:0]        rd_addr;
	logic                 val_we, nxt_we, prv_we, free_we;
	logic [IW-1:0]        val_waddr, nxt_waddr, prv_waddr, free_waddr, free_raddr;
	logic [IW-1:0]        nxt_wdata, prv_wdata;
	logic [DATA_BITS-1:0] val_rd;
	logic [IW-1:0]        nxt_rd, prv_rd, free_rd;
	logic [WIDE_W-1:0]    dump_ext;

	assign in_op     = opcode_t'(s_tdata[OPCODE_W-1:0]);
	assign in_value  = s_tdata[OPCODE_W+VALUE_W-1:OPCODE_W];
	assign in_ext    = WIDE_W'(signed'(in_value));
	assign s_tready  = (state_q == S_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = out_free && (state_q == S_DUMP || state_q == S_EMIT);
	assign hit       = (val_rd == val_q);
	assign at_last   = ((idx_q + CW'(1)) == count_q);
	assign dump_back = (op_q == OP_DUMP_BACK);
	assign dump_ext  = WIDE_W'(signed'(val_rd));

	bdd_ram #(.WIDTH(DATA_BITS), .DEPTH(CAPACITY)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_q),
		.raddr(rd_addr), .rdata(val_rd)
	);

	bdd_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_nxt_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(rd_addr), .rdata(nxt_rd)
	);

	bdd_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prv_ram (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(rd_addr), .rdata(prv_rd)
	);

	bdd_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free_ram (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(cur_q),
		.raddr(free_raddr), .rdata(free_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					case (in_op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (count_q == CW'(CAPACITY)) state_d = S_EMIT;
							else if (free_top_q != '0) state_d = S_ALLOC;
							else state_d = S_PUSH;
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							state_d = (count_q == '0) ? S_EMIT : S_POP;
						end
						OP_DELETE: begin
							state_d = (count_q == '0) ? S_EMIT : S_DEL;
						end
						OP_DUMP_FWD, OP_DUMP_BACK: begin
							state_d = (count_q == '0) ? S_EMIT : S_DUMP;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC: state_d = S_PUSH;
			S_PUSH:  state_d = S_EMIT;
			S_POP:   state_d = S_EMIT;
			S_DEL: begin
				if (hit || at_last) state_d = S_EMIT;
			end
			S_DUMP: begin
				if (out_free && at_last) state_d = S_IDLE;
			end
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_addr    = cur_q;
		val_we     = 1'b0;
		nxt_we     = 1'b0;
		prv_we     = 1'b0;
		free_we    = 1'b0;
		val_waddr  = cur_q;
		nxt_waddr  = cur_q;
		prv_waddr  = cur_q;
		nxt_wdata  = head_q;
		prv_wdata  = tail_q;
		free_waddr = free_top_q[IW-1:0];
		free_raddr = IW'(free_top_q - CW'(1));
		unique case (state_q)
			S_IDLE: begin
				rd_addr = (in_op == OP_DUMP_BACK || in_op == OP_POP_BACK) ? tail_q : head_q;
			end
			S_PUSH: begin
				val_we = 1'b1;
				if (count_q != '0) begin
					nxt_we = 1'b1;
					prv_we = 1'b1;
					if (op_q == OP_PUSH_FRONT) begin
						nxt_waddr = cur_q;
						nxt_wdata = head_q;
						prv_waddr = head_q;
						prv_wdata = cur_q;
					end else begin
						prv_waddr = cur_q;
						prv_wdata = tail_q;
						nxt_waddr = tail_q;
						nxt_wdata = cur_q;
					end
				end
			end
			S_POP: begin
				free_we = 1'b1;
			end
			S_DEL: begin
				rd_addr = nxt_rd;
				if (hit) begin
					free_we = 1'b1;
					if (idx_q != '0 && !at_last) begin
						nxt_we    = 1'b1;
						nxt_waddr = prv_rd;
						nxt_wdata = nxt_rd;
						prv_we    = 1'b1;
						prv_waddr = nxt_rd;
						prv_wdata = prv_rd;
					end
				end
			end
			S_DUMP: begin
				if (out_free && !at_last) rd_addr = dump_back ? prv_rd : nxt_rd;
			end
			default: rd_addr = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			fresh_q    <= '0;
			free_top_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_fire && (in_op == OP_PUSH_FRONT || in_op == OP_PUSH_BACK)
					    && count_q != CW'(CAPACITY) && free_top_q == '0) begin
						fresh_q <= fresh_q + CW'(1);
					end
				end
				S_ALLOC: free_top_q <= free_top_q - CW'(1);
				S_PUSH: begin
					count_q <= count_q + CW'(1);
					if (count_q == '0) begin
						head_q <= cur_q;
						tail_q <= cur_q;
					end else if (op_q == OP_PUSH_FRONT) begin
						head_q <= cur_q;
					end else begin
						tail_q <= cur_q;
					end
				end
				S_POP: begin
					count_q    <= count_q - CW'(1);
					free_top_q <= free_top_q + CW'(1);
					if (count_q > CW'(1)) begin
						if (op_q == OP_POP_FRONT) head_q <= nxt_rd;
						else tail_q <= prv_rd;
					end
				end
				S_DEL: begin
					if (hit) begin
						count_q    <= count_q - CW'(1);
						free_top_q <= free_top_q + CW'(1);
						if (idx_q == '0) begin
							if (count_q > CW'(1)) head_q <= nxt_rd;
						end else if (at_last) begin
							tail_q <= prv_rd;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					op_q  <= in_op;
					val_q <= in_ext[DATA_BITS-1:0];
					idx_q <= '0;
					if (in_op == OP_PUSH_FRONT || in_op == OP_PUSH_BACK) begin
						st_q  <= (count_q == CW'(CAPACITY)) ? STAT_FULL : STAT_OK;
						cur_q <= fresh_q[IW-1:0];
					end else begin
						st_q  <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
						cur_q <= (in_op == OP_DUMP_BACK || in_op == OP_POP_BACK) ? tail_q : head_q;
					end
				end
			end
			S_ALLOC: cur_q <= free_rd;
			S_DEL: begin
				if (!hit) begin
					if (at_last) begin
						st_q <= STAT_NOT_FOUND;
					end else begin
						cur_q <= nxt_rd;
						idx_q <= idx_q + CW'(1);
					end
				end
			end
			S_DUMP: begin
				if (out_free) begin
					out_value_q  <= dump_ext[VALUE_W-1:0];
					out_status_q <= STAT_OK;
					out_last_q   <= at_last;
					out_count_q  <= COUNT_W'(count_q);
					if (!at_last) begin
						cur_q <= dump_back ? prv_rd : nxt_rd;
						idx_q <= idx_q + CW'(1);
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_value_q  <= '0;
					out_status_q <= st_q;
					out_last_q   <= 1'b1;
					out_count_q  <= COUNT_W'(count_q);
				end
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_count_q, out_status_q, out_value_q};

endmodule

FILE: src/bdd_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module bdd_ram
	import bdd_pkg::*;
#(
	parameter int WIDTH = 4,
	parameter int DEPTH = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: dv/deque_checker.sv
// Checker that predicts the deque results from accepted transactions and compares them.
`timescale 1ns / 100ps

module deque_checker
	import bdd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// opcode [2:0], value [34:3], zero fill above
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// value_out [31:0], status [33:32], entry_count [38:34], zero fill above
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 m_tlast,
	output int                   errors,
	output int                   pending,
	output int                   taken,
	output int                   checked,
	output int                   refusals,
	output int                   peak_depth
);

	localparam int DEPTH = CAPACITY_DEF;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic               last;
		logic [COUNT_W-1:0] entries;
	} deque_result_t;

	logic [VALUE_W-1:0] list_values[$];
	deque_result_t      expected_results[$];

	initial begin
		errors     = 0;
		pending    = 0;
		taken      = 0;
		checked    = 0;
		refusals   = 0;
		peak_depth = 0;
	end

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (errors < 30)
			$display("[%0t] %s: expected %h, got %h", $time, what, want, got);
		errors++;
	endtask

	function automatic void add_result(input logic [VALUE_W-1:0] value, input status_t status,
			input logic last);
		deque_result_t r;
		r.value   = value;
		r.status  = status;
		r.last    = last;
		r.entries = COUNT_W'(list_values.size());
		expected_results.push_back(r);
		if (status != STAT_OK)
			refusals++;
	endfunction

	function automatic void predict_operation(input logic [OPCODE_W-1:0] op,
			input logic [VALUE_W-1:0] value);
		int hit;
		int n;
		hit = -1;
		n = list_values.size();
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (n >= DEPTH) begin
					add_result('0, STAT_FULL, 1'b1);
				end else begin
					if (op == OP_PUSH_FRONT)
						list_values.push_front(value);
					else
						list_values.push_back(value);
					add_result('0, STAT_OK, 1'b1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (n == 0) begin
					add_result('0, STAT_EMPTY, 1'b1);
				end else begin
					if (op == OP_POP_FRONT)
						void'(list_values.pop_front());
					else
						void'(list_values.pop_back());
					add_result('0, STAT_OK, 1'b1);
				end
			end
			OP_DELETE: begin
				if (n == 0) begin
					add_result('0, STAT_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < n && hit < 0; i++)
						if (list_values[i] == value)
							hit = i;
					if (hit < 0) begin
						add_result('0, STAT_NOT_FOUND, 1'b1);
					end else begin
						list_values.delete(hit);
						add_result('0, STAT_OK, 1'b1);
					end
				end
			end
			OP_DUMP_FWD, OP_DUMP_BACK: begin
				if (n == 0) begin
					add_result('0, STAT_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						add_result(list_values[op == OP_DUMP_FWD ? i : n - 1 - i], STAT_OK,
							i == n - 1);
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				taken++;
				predict_operation(s_tdata[OPCODE_W-1:0], s_tdata[OPCODE_W +: VALUE_W]);
			end
			if (m_tvalid && m_tready) begin
				checked++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", '0, m_tdata[VALUE_W-1:0]);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[VALUE_W-1:0] !== want.value)
						report_mismatch("value_out", want.value, m_tdata[VALUE_W-1:0]);
					if (m_tdata[VALUE_W +: STATUS_W] !== want.status)
						report_mismatch("status", VALUE_W'(want.status),
							VALUE_W'(m_tdata[VALUE_W +: STATUS_W]));
					if (m_tlast !== want.last)
						report_mismatch("last flag", VALUE_W'(want.last), VALUE_W'(m_tlast));
					if (m_tdata[VALUE_W + STATUS_W +: COUNT_W] !== want.entries)
						report_mismatch("entry_count", VALUE_W'(want.entries),
							VALUE_W'(m_tdata[VALUE_W + STATUS_W +: COUNT_W]));
				end
			end
			pending = expected_results.size();
			if (list_values.size() > peak_depth)
				peak_depth = list_values.size();
		end
	end

endmodule

FILE: dv/tb.sv
// Testbench top that drives directed and random deque operations and gives the verdict.
`timescale 1ns / 100ps

module tb;
	import bdd_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int RANDOM_PER_PHASE = 96;
	localparam int SETTLE_CYCLES    = 64;

	typedef enum {FILL_UP, DRAIN_DOWN, MIXED} bias_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	int errors, pending, taken, checked, refusals, peak_depth;
	int tx_idle_pct = 26;
	int rx_idle_pct = 46;
	int hold_left   = 0;
	int cycle_count = 0;
	logic [VALUE_W-1:0] hot_values[8];

	bounded_deque_with_delete_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	deque_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.errors     (errors),
		.pending    (pending),
		.taken      (taken),
		.checked    (checked),
		.refusals   (refusals),
		.peak_depth (peak_depth)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random, or for a whole stretch while hold_left runs down.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit with %0d results outstanding.", pending);
		$display("Mismatches found");
		$finish;
	end

	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - OPCODE_W - VALUE_W){1'b0}}, value, op};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return hot_values[$urandom_range(7)];
			5: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_op(input bias_t bias);
		int push_pct;
		int pop_pct;
		int delete_pct;
		int r;
		case (bias)
			FILL_UP: begin
				push_pct = 62; pop_pct = 10; delete_pct = 12;
			end
			DRAIN_DOWN: begin
				push_pct = 22; pop_pct = 42; delete_pct = 20;
			end
			default: begin
				push_pct = 40; pop_pct = 24; delete_pct = 18;
			end
		endcase
		r = $urandom_range(99);
		if (r < 3)
			return OP_UNUSED;
		r = $urandom_range(99);
		if (r < push_pct)
			return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		if (r < push_pct + pop_pct)
			return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
		if (r < push_pct + pop_pct + delete_pct)
			return OP_DELETE;
		return $urandom_range(1) ? OP_DUMP_FWD : OP_DUMP_BACK;
	endfunction

	initial begin
		bias_t bias;
		bias = MIXED;
		foreach (hot_values[i])
			hot_values[i] = $urandom();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on the empty list, extreme values, duplicates and the unused opcode.
		send_item(OP_DUMP_FWD, '0);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_BACK, '0);
		send_item(OP_DELETE, 32'h0000_0005);
		send_item(OP_DUMP_BACK, '0);
		send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_item(OP_PUSH_BACK, 32'h8000_0000);
		send_item(OP_PUSH_FRONT, 32'h0000_0000);
		send_item(OP_PUSH_BACK, 32'hFFFF_FFFF);
		send_item(OP_PUSH_BACK, 32'h0000_0000);
		send_item(OP_UNUSED, 32'hFFFF_FFFF);
		send_item(OP_DUMP_FWD, '0);
		send_item(OP_DUMP_BACK, '0);
		send_item(OP_DELETE, 32'h1234_5678);
		send_item(OP_DELETE, 32'h0000_0000);
		send_item(OP_DELETE, 32'h8000_0000);
		send_item(OP_DELETE, 32'h0000_0000);
		send_item(OP_DUMP_FWD, '0);
		send_item(OP_POP_BACK, '0);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_PUSH_BACK, 32'hA5A5_5A5A);
		send_item(OP_DELETE, 32'hA5A5_5A5A);
		send_item(OP_DUMP_BACK, '0);

		// Fill past capacity and dump while the receiver holds off.
		pause_until_drained();
		hold_left = 150;
		repeat (CAPACITY_DEF + 2)
			send_item($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_value());
		hold_left = 80;
		send_item(OP_DUMP_FWD, '0);
		send_item(OP_DUMP_BACK, '0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 26; rx_idle_pct = 46;
				end
				1: begin
					tx_idle_pct = 46; rx_idle_pct = 26;
				end
				default: begin
					tx_idle_pct = 0; rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n % 24 == 0)
					bias = bias_t'($urandom_range(2));
				send_item(pick_op(bias), rand_value());
			end
			if (phase == 0)
				pause_until_drained();
		end

		rx_idle_pct = 0;
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d transactions and checked %0d results, %0d of them refusals",
			taken, checked, refusals);
		$display("for a full list, an empty list or a missing value; peak depth %0d of %0d.",
			peak_depth, CAPACITY_DEF);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
